// File: sv/atr_pkg.sv
// Package for the angular trapezoid ramp: payload structs, widths, turn constants,
// the controller state type and the controller-to-datapath command struct.
// No dependencies.
package atr_pkg;

    localparam int ANGLE_FRACTION_BITS = 6;
    localparam int ANGLE_W = 15;
    localparam int SPEED_W = 12;
    localparam int SCALE_W = 12;
    localparam int CFG_W   = 12;
    localparam int CFG_IDX_W = 2;

    localparam int FULL_TURN_I = 360 << ANGLE_FRACTION_BITS;
    localparam int HALF_TURN_I = 180 << ANGLE_FRACTION_BITS;

    // widths derived from the turn size and the field widths
    localparam int DIST_W = $clog2(HALF_TURN_I + 1);
    localparam int WRAP_W = $clog2(3 * FULL_TURN_I);
    localparam int LHS_W  = CFG_W + 1 + DIST_W;
    localparam int RHS_W  = 2 * SPEED_W;
    localparam int PROD_W = SPEED_W + SCALE_W;
    localparam int AMT_W  = PROD_W - 8;
    localparam int SUM_W  = ANGLE_W + 1;

    localparam logic [ANGLE_W-1:0] FULL_TURN = ANGLE_W'(FULL_TURN_I);
    localparam logic [ANGLE_W-1:0] HALF_TURN = ANGLE_W'(HALF_TURN_I);

    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECEL_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED  = 2'd2;

    localparam logic [CFG_W-1:0] ACCEL_STEP_RST = 12'd16;
    localparam logic [CFG_W-1:0] DECEL_STEP_RST = 12'd16;
    localparam logic [CFG_W-1:0] MAX_SPEED_RST  = 12'd256;

    typedef struct packed {
        logic [ANGLE_W-1:0] target_angle;
        logic [SCALE_W-1:0] step_scale;
    } t_in_item;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle_now;
        logic [SPEED_W-1:0] speed_now;
        logic               snapped;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERROR,
        ST_PROD,
        ST_SPEED,
        ST_ROTATE,
        ST_ANGLE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic calc_err;
        logic calc_prod;
        logic calc_speed;
        logic calc_rot;
        logic commit;
    } t_dp_cmd;

endpackage

// File: sv/angular_trapezoid_ramp_top.sv
// Angular trapezoid ramp: speed profile toward a target angle, one update per
// transaction. Top level joining atr_ctrl and atr_datapath; depends on atr_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries target angle and
//   step scale; output channel (o_out_valid / i_out_stall / o_out_data) returns the
//   new angle, speed and a snap flag, one result per input transaction.
//   Pacing: the next input is taken on the cycle the previous result is loaded,
//   and not before, as each input runs the dependent chain error -> braking
//   products -> speed update -> rotation product -> angle update, each step
//   registered, with the result loaded into the output register at the end.
//   Configuration (i_cfg_we / i_cfg_idx / i_cfg_data) writes accel_step (0),
//   decel_step (1) and max_speed (2); write only while the block is idle.
//   Reset (synchronous, active low) sets angle and speed to zero, registers to
//   their defaults and empties the output register.
//   When the receiver stalls, the result is held; one further input may be
//   accepted and worked on, then the block waits with its result ready.
module angular_trapezoid_ramp_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [atr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [atr_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  atr_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output atr_pkg::t_out_item            o_out_data
);

    atr_pkg::t_dp_cmd cmd;

    atr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    atr_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_out_data (o_out_data)
    );

endmodule

// File: sv/atr_ctrl.sv
// Controller of the angular trapezoid ramp: sequences the datapath steps and
// owns the input/output handshakes. Depends on atr_pkg.
module atr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output atr_pkg::t_dp_cmd o_cmd
);

    atr_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            out_free;
    logic            in_ready;
    logic            accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= atr_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        out_free = !r_out_valid || !i_out_stall;
        // a new transaction may enter on the cycle the previous one commits
        in_ready = (r_state == atr_pkg::ST_IDLE) ||
                   ((r_state == atr_pkg::ST_ANGLE) && out_free);
        accept   = i_in_valid && in_ready;

        n_state  = r_state;
        o_cmd    = '0;
        o_cmd.load_in = accept;

        case (r_state)
            atr_pkg::ST_IDLE: begin
                if (accept) n_state = atr_pkg::ST_ERROR;
            end
            atr_pkg::ST_ERROR: begin
                o_cmd.calc_err = 1'b1;
                n_state = atr_pkg::ST_PROD;
            end
            atr_pkg::ST_PROD: begin
                o_cmd.calc_prod = 1'b1;
                n_state = atr_pkg::ST_SPEED;
            end
            atr_pkg::ST_SPEED: begin
                o_cmd.calc_speed = 1'b1;
                n_state = atr_pkg::ST_ROTATE;
            end
            atr_pkg::ST_ROTATE: begin
                o_cmd.calc_rot = 1'b1;
                n_state = atr_pkg::ST_ANGLE;
            end
            atr_pkg::ST_ANGLE: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = accept ? atr_pkg::ST_ERROR : atr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = atr_pkg::ST_IDLE;
            end
        endcase

        if (o_cmd.commit)
            n_out_valid = 1'b1;
        else if (!i_out_stall)
            n_out_valid = 1'b0;
        else
            n_out_valid = r_out_valid;
    end

    assign o_in_stall  = !in_ready;
    assign o_out_valid = r_out_valid;

endmodule

// File: sv/atr_datapath.sv
// Datapath of the angular trapezoid ramp: configuration registers, angle and
// speed state, error, braking test, speed update and rotation. Depends on atr_pkg.
module atr_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [atr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [atr_pkg::CFG_W-1:0]      i_cfg_data,
    input  atr_pkg::t_in_item              i_in_data,
    input  atr_pkg::t_dp_cmd               i_cmd,
    output atr_pkg::t_out_item             o_out_data
);

    localparam logic [atr_pkg::WRAP_W-1:0] WRAP_BIAS =
        atr_pkg::WRAP_W'(atr_pkg::FULL_TURN_I + atr_pkg::HALF_TURN_I);
    localparam logic [atr_pkg::WRAP_W-1:0] WRAP_FULL  = atr_pkg::WRAP_W'(atr_pkg::FULL_TURN_I);
    localparam logic [atr_pkg::WRAP_W-1:0] WRAP_FULL2 =
        atr_pkg::WRAP_W'(2 * atr_pkg::FULL_TURN_I);
    localparam logic [atr_pkg::WRAP_W-1:0] WRAP_HALF  = atr_pkg::WRAP_W'(atr_pkg::HALF_TURN_I);
    localparam logic [atr_pkg::AMT_W-1:0]  AMT_HALF   = atr_pkg::AMT_W'(atr_pkg::HALF_TURN_I);
    localparam logic [atr_pkg::SUM_W-1:0]  SUM_FULL   = atr_pkg::SUM_W'(atr_pkg::FULL_TURN_I);

    logic [atr_pkg::CFG_W-1:0]   r_accel, r_decel, r_max;
    logic [atr_pkg::ANGLE_W-1:0] r_angle, n_angle;
    logic [atr_pkg::SPEED_W-1:0] r_speed, n_speed;
    logic [atr_pkg::ANGLE_W-1:0] r_target;
    logic [atr_pkg::SCALE_W-1:0] r_scale;
    logic [atr_pkg::DIST_W-1:0]  r_dist;
    logic                        r_neg;
    logic [atr_pkg::LHS_W-1:0]   r_lhs;
    logic [atr_pkg::RHS_W-1:0]   r_rhs;
    logic                        r_snap;
    logic [atr_pkg::AMT_W-1:0]   r_amount;
    atr_pkg::t_out_item          r_out;

    logic [atr_pkg::ANGLE_W-1:0] tgt_red;
    logic [atr_pkg::WRAP_W-1:0]  wrap_raw, wrap_mod;
    logic                        err_neg;
    logic [atr_pkg::DIST_W-1:0]  err_dist;
    logic                        snap;
    logic [atr_pkg::SPEED_W:0]   spd_sum;
    logic [atr_pkg::PROD_W-1:0]  rot_prod;
    logic [atr_pkg::AMT_W-1:0]   amt_clamped;
    logic [atr_pkg::SUM_W-1:0]   ang_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel <= atr_pkg::ACCEL_STEP_RST;
            r_decel <= atr_pkg::DECEL_STEP_RST;
            r_max   <= atr_pkg::MAX_SPEED_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                atr_pkg::CFG_ACCEL_STEP: r_accel <= i_cfg_data;
                atr_pkg::CFG_DECEL_STEP: r_decel <= i_cfg_data;
                atr_pkg::CFG_MAX_SPEED:  r_max   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // target reduced modulo a full turn (one subtract covers the 15-bit range)
    always_comb begin
        tgt_red = (i_in_data.target_angle >= atr_pkg::FULL_TURN) ?
                  i_in_data.target_angle - atr_pkg::FULL_TURN : i_in_data.target_angle;
    end

    // shortest error, wrapped around half a turn
    always_comb begin
        wrap_raw = atr_pkg::WRAP_W'(r_target) + WRAP_BIAS - atr_pkg::WRAP_W'(r_angle);
        if (wrap_raw >= WRAP_FULL2)
            wrap_mod = wrap_raw - WRAP_FULL2;
        else if (wrap_raw >= WRAP_FULL)
            wrap_mod = wrap_raw - WRAP_FULL;
        else
            wrap_mod = wrap_raw;
        err_neg  = wrap_mod < WRAP_HALF;
        err_dist = err_neg ? atr_pkg::DIST_W'(WRAP_HALF - wrap_mod)
                           : atr_pkg::DIST_W'(wrap_mod - WRAP_HALF);
    end

    // speed update: snap, accelerate or brake
    always_comb begin
        snap    = r_dist < atr_pkg::DIST_W'(r_speed);
        spd_sum = {1'b0, r_speed} + {1'b0, r_accel};
        if (snap)
            n_speed = '0;
        else if (r_lhs > atr_pkg::LHS_W'(r_rhs))
            n_speed = (spd_sum > {1'b0, r_max}) ? r_max : spd_sum[atr_pkg::SPEED_W-1:0];
        else
            n_speed = (r_speed > r_decel) ? r_speed - r_decel : '0;
    end

    assign rot_prod = atr_pkg::PROD_W'(r_speed) * atr_pkg::PROD_W'(r_scale);

    // rotation clamped to half a turn, then applied in the error's direction
    always_comb begin
        amt_clamped = (r_amount > AMT_HALF) ? AMT_HALF : r_amount;
        if (r_neg)
            ang_sum = atr_pkg::SUM_W'(r_angle) + SUM_FULL - atr_pkg::SUM_W'(amt_clamped);
        else
            ang_sum = atr_pkg::SUM_W'(r_angle) + atr_pkg::SUM_W'(amt_clamped);
        n_angle = (ang_sum >= SUM_FULL) ? atr_pkg::ANGLE_W'(ang_sum - SUM_FULL)
                                        : atr_pkg::ANGLE_W'(ang_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
            r_speed <= '0;
        end else begin
            if (i_cmd.calc_speed) begin
                r_speed <= n_speed;
                if (snap) r_angle <= r_target;
            end else if (i_cmd.commit) begin
                r_angle <= n_angle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_target <= tgt_red;
            r_scale  <= i_in_data.step_scale;
        end
        if (i_cmd.calc_err) begin
            r_dist <= err_dist;
            r_neg  <= err_neg;
        end
        if (i_cmd.calc_prod) begin
            r_lhs <= atr_pkg::LHS_W'({r_decel, 1'b0}) * atr_pkg::LHS_W'(r_dist);
            r_rhs <= atr_pkg::RHS_W'(r_speed) * atr_pkg::RHS_W'(r_speed);
        end
        if (i_cmd.calc_speed)
            r_snap <= snap;
        if (i_cmd.calc_rot)
            r_amount <= rot_prod[atr_pkg::PROD_W-1:8];
        if (i_cmd.commit) begin
            r_out.angle_now <= n_angle;
            r_out.speed_now <= r_speed;
            r_out.snapped   <= r_snap;
        end
    end

    assign o_out_data = r_out;

endmodule

// File: sv/atr_checker.sv
// Port-level assertions for angular_trapezoid_ramp_top, attached by bind.
// Depends on atr_pkg.
module atr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input atr_pkg::t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken twice in a row");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.angle_now < atr_pkg::FULL_TURN)
        else $error("angle beyond a full turn");

    a_snap_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.snapped |-> o_out_data.speed_now == '0)
        else $error("snapped with non-zero speed");

endmodule

bind angular_trapezoid_ramp_top atr_checker u_atr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// File: tb/angular_trapezoid_ramp_top_tb.sv
`timescale 1ns / 1ps
// Testbench for angular_trapezoid_ramp_top: a directed table followed by random target runs.
// It predicts each result and checks it field by field. Depends on atr_pkg and the RTL.
module angular_trapezoid_ramp_top_tb;

    typedef struct {
        bit                            is_write;
        logic [atr_pkg::CFG_IDX_W-1:0] reg_idx;
        logic [atr_pkg::CFG_W-1:0]     reg_val;
        atr_pkg::t_in_item             item;
        bit                            typed;
        atr_pkg::t_out_item            result;
    } t_plan_row;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [atr_pkg::CFG_IDX_W-1:0] cfg_idx = atr_pkg::CFG_ACCEL_STEP;
    logic [atr_pkg::CFG_W-1:0]     cfg_data = '0;
    logic                          in_valid = 1'b0;
    atr_pkg::t_in_item             in_data = '0;
    logic                          out_stall = 1'b0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    atr_pkg::t_out_item            o_out_data;

    // predicted block state and register copies
    int model_angle, model_speed;
    int model_accel, model_decel, model_max;

    atr_pkg::t_out_item pending_results[$];
    t_plan_row          directed_plan[$];

    int send_gap_max = 19;
    int recv_gap_max = 19;
    int hold_off_cycles = 0;
    int mismatch_count = 0;
    int items_sent = 0, results_checked = 0, writes_done = 0;
    int snaps_expected = 0, turns_clamped = 0, long_holds = 0;

    angular_trapezoid_ramp_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    always #10 clk = ~clk;

    initial begin : watchdog
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic atr_pkg::t_out_item advance_ramp(input atr_pkg::t_in_item it);
        int                 goal, scale, wrapped, span, speed, amount;
        bit                 backwards, snap;
        longint             lhs, rhs;
        atr_pkg::t_out_item res;
        goal      = int'(it.target_angle) % atr_pkg::FULL_TURN_I;
        scale     = int'(it.step_scale);
        wrapped   = (goal + atr_pkg::FULL_TURN_I - model_angle + atr_pkg::HALF_TURN_I) %
                    atr_pkg::FULL_TURN_I;
        backwards = wrapped < atr_pkg::HALF_TURN_I;
        span      = backwards ? atr_pkg::HALF_TURN_I - wrapped : wrapped - atr_pkg::HALF_TURN_I;
        speed     = model_speed;
        // braking test uses the speed before this update
        lhs       = 2 * longint'(model_decel) * longint'(span);
        rhs       = longint'(speed) * longint'(speed);
        snap      = 1'b0;
        if (span < speed) begin
            model_angle = goal;
            speed = 0;
            snap = 1'b1;
        end else if (lhs > rhs) begin
            speed = speed + model_accel;
            if (speed > model_max)
                speed = model_max;
        end else begin
            speed = (speed > model_decel) ? speed - model_decel : 0;
        end
        model_speed = speed & 'hFFF;
        amount = (model_speed * scale) >> 8;
        if (amount > atr_pkg::HALF_TURN_I) begin
            amount = atr_pkg::HALF_TURN_I;
            turns_clamped++;
        end
        if (backwards)
            model_angle = (model_angle + atr_pkg::FULL_TURN_I - amount) % atr_pkg::FULL_TURN_I;
        else
            model_angle = (model_angle + amount) % atr_pkg::FULL_TURN_I;
        if (snap)
            snaps_expected++;
        res.angle_now = atr_pkg::ANGLE_W'(model_angle);
        res.speed_now = atr_pkg::SPEED_W'(model_speed);
        res.snapped   = snap;
        return res;
    endfunction

    function automatic t_plan_row tick_row(input int tgt, input int scl);
        t_plan_row r;
        r = '{default: '0};
        r.item.target_angle = atr_pkg::ANGLE_W'(tgt);
        r.item.step_scale   = atr_pkg::SCALE_W'(scl);
        return r;
    endfunction

    function automatic t_plan_row typed_row(input int tgt, input int scl, input int ang,
                                            input int spd, input bit snap);
        t_plan_row r;
        r = tick_row(tgt, scl);
        r.typed = 1'b1;
        r.result.angle_now = atr_pkg::ANGLE_W'(ang);
        r.result.speed_now = atr_pkg::SPEED_W'(spd);
        r.result.snapped   = snap;
        return r;
    endfunction

    function automatic t_plan_row reg_row(input logic [atr_pkg::CFG_IDX_W-1:0] idx,
                                          input int val);
        t_plan_row r;
        r = '{default: '0};
        r.is_write = 1'b1;
        r.reg_idx  = idx;
        r.reg_val  = atr_pkg::CFG_W'(val);
        return r;
    endfunction

    function automatic int pick_setting(input int lowest);
        case ($urandom_range(0, 5))
            0:       return lowest;
            1:       return 4095;
            2, 3:    return $urandom_range(1, 64);
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    task automatic offer_item(input atr_pkg::t_in_item it, input bit typed,
                              input atr_pkg::t_out_item fixed);
        int                 gap;
        atr_pkg::t_out_item want;
        gap = $urandom_range(0, send_gap_max);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (o_in_stall !== 1'b0);
        want = advance_ramp(it);
        pending_results.push_back(typed ? fixed : want);
        items_sent++;
    endtask

    // registers only change with nothing in flight
    task automatic write_reg(input logic [atr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [atr_pkg::CFG_W-1:0] val);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we   <= 1'b0;
        case (idx)
            atr_pkg::CFG_ACCEL_STEP: model_accel = int'(val);
            atr_pkg::CFG_DECEL_STEP: model_decel = int'(val);
            atr_pkg::CFG_MAX_SPEED:  model_max   = int'(val);
            default: ;
        endcase
        writes_done++;
    endtask

    task automatic check_result(input atr_pkg::t_out_item got);
        atr_pkg::t_out_item want;
        if (pending_results.size() == 0) begin
            if (mismatch_count < 10)
                $display("%0t: result with nothing pending: angle %0d speed %0d snap %0b",
                         $realtime, got.angle_now, got.speed_now, got.snapped);
            mismatch_count++;
        end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (got.angle_now !== want.angle_now || got.speed_now !== want.speed_now ||
                got.snapped !== want.snapped) begin
                if (mismatch_count < 10)
                    $display("%0t: mismatch exp/act angle %0d/%0d speed %0d/%0d snap %0b/%0b",
                             $realtime, want.angle_now, got.angle_now, want.speed_now,
                             got.speed_now, want.snapped, got.snapped);
                mismatch_count++;
            end
        end
    endtask

    initial begin : drain_results
        int gap;
        forever begin
            if (hold_off_cycles > 0) begin
                gap = hold_off_cycles;
                hold_off_cycles = 0;
                long_holds++;
            end else begin
                gap = $urandom_range(0, recv_gap_max);
            end
            @(negedge clk);
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (o_out_valid !== 1'b1);
            check_result(o_out_data);
        end
    end

    initial begin : stimulus
        atr_pkg::t_in_item           it;
        int                          n, run;
        bit                          noisy;
        logic [atr_pkg::ANGLE_W-1:0] goal;
        model_angle = 0;
        model_speed = 0;
        model_accel = int'(atr_pkg::ACCEL_STEP_RST);
        model_decel = int'(atr_pkg::DECEL_STEP_RST);
        model_max   = int'(atr_pkg::MAX_SPEED_RST);
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // after reset, a short ramp, then a snap and a zero error
        directed_plan.push_back(typed_row(0, 0, 0, 0, 1'b0));
        directed_plan.push_back(typed_row(5760, 256, 16, 16, 1'b0));
        directed_plan.push_back(typed_row(5760, 4095, 527, 32, 1'b0));
        directed_plan.push_back(typed_row(537, 0, 537, 0, 1'b1));
        directed_plan.push_back(typed_row(537, 4095, 537, 0, 1'b0));
        directed_plan.push_back(reg_row(atr_pkg::CFG_ACCEL_STEP, 4095));
        directed_plan.push_back(reg_row(atr_pkg::CFG_DECEL_STEP, 4095));
        directed_plan.push_back(reg_row(atr_pkg::CFG_MAX_SPEED, 4095));
        // full speed, full scale: the turn is clamped to half a revolution
        directed_plan.push_back(tick_row(23039, 4095));
        // speed now above the limit
        directed_plan.push_back(reg_row(atr_pkg::CFG_MAX_SPEED, 100));
        directed_plan.push_back(tick_row(0, 4095));
        directed_plan.push_back(reg_row(atr_pkg::CFG_MAX_SPEED, 4095));
        // targets past and at a full turn, then half a turn
        directed_plan.push_back(tick_row(32767, 4095));
        directed_plan.push_back(tick_row(23040, 128));
        directed_plan.push_back(tick_row(11520, 4095));
        // no braking at all
        directed_plan.push_back(reg_row(atr_pkg::CFG_DECEL_STEP, 0));
        directed_plan.push_back(tick_row(5000, 300));
        directed_plan.push_back(tick_row(15000, 300));
        directed_plan.push_back(reg_row(atr_pkg::CFG_ACCEL_STEP, 0));
        directed_plan.push_back(reg_row(atr_pkg::CFG_MAX_SPEED, 0));
        directed_plan.push_back(tick_row(1000, 4095));
        directed_plan.push_back(tick_row(20000, 4095));
        directed_plan.push_back(reg_row(atr_pkg::CFG_ACCEL_STEP, 16));
        directed_plan.push_back(reg_row(atr_pkg::CFG_DECEL_STEP, 1));
        directed_plan.push_back(reg_row(atr_pkg::CFG_MAX_SPEED, 256));
        directed_plan.push_back(tick_row(16384, 2048));
        directed_plan.push_back(tick_row(8191, 1));
        directed_plan.push_back(tick_row(0, 256));

        foreach (directed_plan[r]) begin
            if (directed_plan[r].is_write)
                write_reg(directed_plan[r].reg_idx, directed_plan[r].reg_val);
            else
                offer_item(directed_plan[r].item, directed_plan[r].typed,
                           directed_plan[r].result);
        end

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_reg(atr_pkg::CFG_ACCEL_STEP, atr_pkg::ACCEL_STEP_RST);
                    write_reg(atr_pkg::CFG_DECEL_STEP, atr_pkg::DECEL_STEP_RST);
                    write_reg(atr_pkg::CFG_MAX_SPEED, atr_pkg::MAX_SPEED_RST);
                end
                1: begin
                    write_reg(atr_pkg::CFG_ACCEL_STEP, 12'd4095);
                    write_reg(atr_pkg::CFG_DECEL_STEP, 12'd4095);
                    write_reg(atr_pkg::CFG_MAX_SPEED, 12'd4095);
                end
                default: begin
                    write_reg(atr_pkg::CFG_ACCEL_STEP, atr_pkg::CFG_W'(pick_setting(0)));
                    write_reg(atr_pkg::CFG_DECEL_STEP, atr_pkg::CFG_W'(pick_setting(1)));
                    write_reg(atr_pkg::CFG_MAX_SPEED, atr_pkg::CFG_W'(pick_setting(0)));
                end
            endcase
            send_gap_max = (phase % 4 == 1 || phase % 4 == 2) ? 0 : 19;
            recv_gap_max = (phase % 4 == 1 || phase % 4 == 3) ? 0 : 19;
            // receiver holds off while the sender keeps pushing
            if (phase == 2)
                hold_off_cycles = 300;

            n = 0;
            while (n < 100) begin
                noisy = ($urandom_range(0, 7) == 0);
                run = noisy ? $urandom_range(1, 6) : $urandom_range(1, 60);
                if ($urandom_range(0, 9) == 0)
                    goal = atr_pkg::ANGLE_W'($urandom_range(0, 32767));
                else
                    goal = atr_pkg::ANGLE_W'($urandom_range(0, atr_pkg::FULL_TURN_I - 1));
                for (int k = 0; k < run && n < 100; k++) begin
                    it.target_angle = noisy ? atr_pkg::ANGLE_W'($urandom_range(0, 32767))
                                            : goal;
                    if ($urandom_range(0, 3) == 0)
                        it.step_scale = atr_pkg::SCALE_W'($urandom_range(0, 4095));
                    else
                        it.step_scale = atr_pkg::SCALE_W'($urandom_range(32, 512));
                    offer_item(it, 1'b0, '0);
                    n++;
                end
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Ran %0d transactions through %0d register writes, %0d results checked.",
                 items_sent, writes_done, results_checked);
        $display("Saw %0d snaps, %0d clamped turns, %0d long output hold(s).",
                 snaps_expected, turns_clamped, long_holds);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
